/* hdl/wmp_pkg.sv */
package wmp_pkg;

   localparam int COORD_BITS_DEFAULT = 12;
   localparam int HIST_DEPTH         = 5;
   localparam int COUNT_BITS         = 3;

   // Divisors of the weighted delta sum for two, three, four and five points.
   localparam int DIV_PAIR  = 1;
   localparam int DIV_THREE = 3;
   localparam int DIV_FOUR  = 6;
   localparam int DIV_FIVE  = 10;

   typedef struct packed {
      logic sum_load;
      logic prod_load;
      logic out_load;
   } stage_en_type;

endpackage

/* hdl/wmp_cell.sv */
module wmp_cell
   import wmp_pkg::*;
#(
   parameter int CENTER_BITS = COORD_BITS_DEFAULT + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   shift,
   input  logic                   flush,
   input  logic [CENTER_BITS-1:0] x_in,
   input  logic [CENTER_BITS-1:0] y_in,
   input  logic                   valid_in,
   output logic [CENTER_BITS-1:0] x_ff,
   output logic [CENTER_BITS-1:0] y_ff,
   output logic                   valid_ff
);

   logic valid_in_gated;

   assign valid_in_gated = valid_in & ~flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (shift) begin
         valid_ff <= valid_in_gated;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

endmodule

/* hdl/wmp_axis.sv */
module wmp_axis
   import wmp_pkg::*;
#(
   parameter int CENTER_BITS = COORD_BITS_DEFAULT + 1
) (
   input  logic                     clock,
   input  stage_en_type             stage_en,
   input  logic [CENTER_BITS-1:0]   hist [HIST_DEPTH],
   input  logic [HIST_DEPTH-1:0]    hist_valid,
   input  logic [COUNT_BITS-1:0]    points_cells,
   input  logic [COUNT_BITS-1:0]    points_sum,
   output logic [CENTER_BITS-1:0]   center_ff,
   output logic [CENTER_BITS+1:0]   pred_ff
);

   localparam int SUM_BITS  = CENTER_BITS + 3;
   localparam int MAG_BITS  = CENTER_BITS + 2;
   localparam int NUM_BITS  = CENTER_BITS + 4;
   localparam int SHIFT     = NUM_BITS + 5;
   localparam int PROD_BITS = NUM_BITS + SHIFT;
   localparam int PRED_BITS = CENTER_BITS + 2;

   localparam logic [SHIFT-1:0] RECIP_PAIR  =
      SHIFT'(((64'd1 << SHIFT) + 64'd1) / (64'd2 * DIV_PAIR));
   localparam logic [SHIFT-1:0] RECIP_THREE =
      SHIFT'(((64'd1 << SHIFT) + 64'd5) / (64'd2 * DIV_THREE));
   localparam logic [SHIFT-1:0] RECIP_FOUR  =
      SHIFT'(((64'd1 << SHIFT) + 64'd11) / (64'd2 * DIV_FOUR));
   localparam logic [SHIFT-1:0] RECIP_FIVE  =
      SHIFT'(((64'd1 << SHIFT) + 64'd19) / (64'd2 * DIV_FIVE));

   logic [MAG_BITS-1:0]         older_sum;
   logic [CENTER_BITS+2:0]      newest_scaled;
   logic [COUNT_BITS-1:0]       newest_weight;
   logic signed [SUM_BITS-1:0]  sum_in;
   logic signed [SUM_BITS-1:0]  sum_ff;
   logic [CENTER_BITS-1:0]      h0_sum_ff;

   logic [SUM_BITS-1:0]         sum_abs;
   logic [NUM_BITS-1:0]         divisor;
   logic [SHIFT-1:0]            recip;
   logic [NUM_BITS-1:0]         numer;
   logic [PROD_BITS-1:0]        prod_in;
   logic [PROD_BITS-1:0]        prod_ff;
   logic                        neg_ff;
   logic [CENTER_BITS-1:0]      h0_prod_ff;

   logic [PRED_BITS-1:0]        quot;
   logic [PRED_BITS-1:0]        pred_in;

   // The weighted delta sum telescopes to (n-1) times the newest centre less
   // the older centres still held.
   always_comb begin
      older_sum = '0;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         if (hist_valid[i]) begin
            older_sum = older_sum + MAG_BITS'(hist[i]);
         end
      end
      newest_weight = (points_cells == '0) ? '0 : points_cells - 1'b1;
      newest_scaled = (CENTER_BITS + 3)'(newest_weight) * (CENTER_BITS + 3)'(hist[0]);
      sum_in        = $signed({1'b0, newest_scaled[MAG_BITS-1:0]})
                    - $signed({1'b0, older_sum});
   end

   always_ff @(posedge clock) begin
      if (stage_en.sum_load) begin
         sum_ff    <= sum_in;
         h0_sum_ff <= hist[0];
      end
   end

   always_comb begin
      sum_abs = sum_ff[SUM_BITS-1] ? SUM_BITS'(-sum_ff) : SUM_BITS'(sum_ff);
      case (points_sum)
         3'd3: begin
            divisor = NUM_BITS'(DIV_THREE);
            recip   = RECIP_THREE;
         end
         3'd4: begin
            divisor = NUM_BITS'(DIV_FOUR);
            recip   = RECIP_FOUR;
         end
         3'd5: begin
            divisor = NUM_BITS'(DIV_FIVE);
            recip   = RECIP_FIVE;
         end
         default: begin
            divisor = NUM_BITS'(DIV_PAIR);
            recip   = RECIP_PAIR;
         end
      endcase
      numer   = NUM_BITS'({sum_abs[MAG_BITS-1:0], 1'b0}) + divisor;
      prod_in = PROD_BITS'(numer) * PROD_BITS'(recip);
   end

   always_ff @(posedge clock) begin
      if (stage_en.prod_load) begin
         prod_ff    <= prod_in;
         neg_ff     <= sum_ff[SUM_BITS-1];
         h0_prod_ff <= h0_sum_ff;
      end
   end

   always_comb begin
      quot    = prod_ff[SHIFT+PRED_BITS-1:SHIFT];
      pred_in = {2'b00, h0_prod_ff} + (neg_ff ? -quot : quot);
   end

   always_ff @(posedge clock) begin
      if (stage_en.out_load) begin
         pred_ff   <= pred_in;
         center_ff <= h0_prod_ff;
      end
   end

endmodule

/* hdl/weighted_motion_predictor_unit.sv */
// Weighted motion predictor for one tracked object.
// A request on the req_ channel carries one frame's bounding box; req_tuser
// set starts a new track and empties the history before the box is stored.
// Each request gives exactly one response on the rsp_ channel with the box
// centre, the predicted next centre and the number of history points used.
// The history is a row of five cells that shift once per accepted request.
// An accepted request passes the history cells, sum, product and output
// registers before its response appears. One request can be accepted in
// every cycle; only when every stage is full does a stalled receiver hold
// req_tready low. The pipeline behind the history cells has a ready chain,
// so requests keep flowing while a response waits and empty stages fill up.
// Reset empties the history and the pipeline at once; there is no clearing
// pass, and requests are accepted in the first cycle after reset.
module weighted_motion_predictor_unit
   import wmp_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // box_left, box_top, box_width, box_height, zero padding
   input  logic [((4*COORD_BITS+2+7)/8)*8-1:0] req_tdata,
   // new_track
   input  logic req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // center_x, center_y, pred_x, pred_y, points_held, zero padding
   output logic [((4*COORD_BITS+11+7)/8)*8-1:0] rsp_tdata
);

   localparam int CENTER_BITS = COORD_BITS + 1;
   localparam int PRED_BITS   = COORD_BITS + 3;
   localparam int RSP_BITS    = ((4*COORD_BITS+11+7)/8)*8;

   logic [COORD_BITS-1:0]   box_left;
   logic [COORD_BITS-1:0]   box_top;
   logic [COORD_BITS:0]     box_width;
   logic [COORD_BITS:0]     box_height;
   logic [COORD_BITS+1:0]   sum_x;
   logic [COORD_BITS+1:0]   sum_y;
   logic [CENTER_BITS-1:0]  center_x;
   logic [CENTER_BITS-1:0]  center_y;

   logic                    accept;
   logic                    cells_valid_ff;
   logic                    sum_valid_ff;
   logic                    prod_valid_ff;
   logic                    rsp_valid_ff;
   logic                    cells_load;
   stage_en_type            stage_en;

   logic [CENTER_BITS-1:0]  hist_x [HIST_DEPTH];
   logic [CENTER_BITS-1:0]  hist_y [HIST_DEPTH];
   logic [HIST_DEPTH-1:0]   hist_valid;
   logic [CENTER_BITS-1:0]  link_x [HIST_DEPTH];
   logic [CENTER_BITS-1:0]  link_y [HIST_DEPTH];
   logic [HIST_DEPTH-1:0]   link_valid;

   logic [COUNT_BITS-1:0]   points_cells;
   logic [COUNT_BITS-1:0]   points_sum_ff;
   logic [COUNT_BITS-1:0]   points_prod_ff;
   logic [COUNT_BITS-1:0]   points_out_ff;

   logic [CENTER_BITS-1:0]  out_center_x;
   logic [CENTER_BITS-1:0]  out_center_y;
   logic [PRED_BITS-1:0]    out_pred_x;
   logic [PRED_BITS-1:0]    out_pred_y;

   assign box_left   = req_tdata[COORD_BITS-1:0];
   assign box_top    = req_tdata[2*COORD_BITS-1:COORD_BITS];
   assign box_width  = req_tdata[3*COORD_BITS:2*COORD_BITS];
   assign box_height = req_tdata[4*COORD_BITS+1:3*COORD_BITS+1];

   assign sum_x    = {1'b0, box_left, 1'b0} + {1'b0, box_width};
   assign sum_y    = {1'b0, box_top, 1'b0} + {1'b0, box_height};
   assign center_x = sum_x[COORD_BITS+1:1];
   assign center_y = sum_y[COORD_BITS+1:1];

   always_comb begin
      stage_en.out_load  = ~rsp_valid_ff | rsp_tready;
      stage_en.prod_load = ~prod_valid_ff | stage_en.out_load;
      stage_en.sum_load  = ~sum_valid_ff | stage_en.prod_load;
      cells_load         = ~cells_valid_ff | stage_en.sum_load;
   end

   assign req_tready = cells_load;
   assign accept     = req_tvalid & cells_load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_valid_ff <= 1'b0;
         sum_valid_ff   <= 1'b0;
         prod_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cells_load) begin
            cells_valid_ff <= req_tvalid;
         end
         if (stage_en.sum_load) begin
            sum_valid_ff <= cells_valid_ff;
         end
         if (stage_en.prod_load) begin
            prod_valid_ff <= sum_valid_ff;
         end
         if (stage_en.out_load) begin
            rsp_valid_ff <= prod_valid_ff;
         end
      end
   end

   always_comb begin
      link_x[0]     = center_x;
      link_y[0]     = center_y;
      link_valid[0] = 1'b1;
      for (int i = 1; i < HIST_DEPTH; i++) begin
         link_x[i]     = hist_x[i-1];
         link_y[i]     = hist_y[i-1];
         link_valid[i] = hist_valid[i-1];
      end
   end

   for (genvar g = 0; g < HIST_DEPTH; g++) begin : g_cell
      wmp_cell #(
         .CENTER_BITS (CENTER_BITS)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift    (accept),
         .flush    (req_tuser && (g != 0)),
         .x_in     (link_x[g]),
         .y_in     (link_y[g]),
         .valid_in (link_valid[g]),
         .x_ff     (hist_x[g]),
         .y_ff     (hist_y[g]),
         .valid_ff (hist_valid[g])
      );
   end

   always_comb begin
      points_cells = '0;
      for (int i = 0; i < HIST_DEPTH; i++) begin
         points_cells = points_cells + COUNT_BITS'(hist_valid[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.sum_load) begin
         points_sum_ff <= points_cells;
      end
      if (stage_en.prod_load) begin
         points_prod_ff <= points_sum_ff;
      end
      if (stage_en.out_load) begin
         points_out_ff <= points_prod_ff;
      end
   end

   wmp_axis #(
      .CENTER_BITS (CENTER_BITS)
   ) u_axis_x (
      .clock        (clock),
      .stage_en     (stage_en),
      .hist         (hist_x),
      .hist_valid   (hist_valid),
      .points_cells (points_cells),
      .points_sum   (points_sum_ff),
      .center_ff    (out_center_x),
      .pred_ff      (out_pred_x)
   );

   wmp_axis #(
      .CENTER_BITS (CENTER_BITS)
   ) u_axis_y (
      .clock        (clock),
      .stage_en     (stage_en),
      .hist         (hist_y),
      .hist_valid   (hist_valid),
      .points_cells (points_cells),
      .points_sum   (points_sum_ff),
      .center_ff    (out_center_y),
      .pred_ff      (out_pred_y)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_BITS'({points_out_ff, out_pred_y, out_pred_x,
                                  out_center_y, out_center_x});

   a_points_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (points_out_ff != '0) && (points_out_ff <= COUNT_BITS'(HIST_DEPTH)))
      else $error("Response carries an impossible point count.");

   a_new_track: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser) |=> (hist_valid == HIST_DEPTH'(1)))
      else $error("History not emptied by a new track.");

   a_shift: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_tuser) |=>
         (hist_valid == {$past(hist_valid[HIST_DEPTH-2:0]), 1'b1}))
      else $error("History cells did not shift on a request.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_tready)
      else $error("Request refused while no response is waiting.");

endmodule

/* tb/weighted_motion_predictor_unit_tb.sv */
`timescale 1ns / 1ps

module weighted_motion_predictor_unit_tb;
   import wmp_pkg::*;

   localparam int COORD_BITS  = COORD_BITS_DEFAULT;
   localparam int CENTRE_BITS = COORD_BITS + 1;
   localparam int PRED_BITS   = COORD_BITS + 3;
   localparam int REQ_BITS    = ((4*COORD_BITS+2+7)/8)*8;
   localparam int RSP_BITS    = ((4*COORD_BITS+11+7)/8)*8;
   localparam int MAX_COORD   = (1 << COORD_BITS) - 1;
   localparam int MAX_SIZE    = 1 << COORD_BITS;
   localparam int DIRECTED_ROWS = 25;
   localparam int PHASE_ITEMS   = 375;
   localparam int DRAIN_CYCLES  = 8;

   typedef struct packed {
      logic [CENTRE_BITS-1:0] center_x;
      logic [CENTRE_BITS-1:0] center_y;
      logic [PRED_BITS-1:0]   pred_x;
      logic [PRED_BITS-1:0]   pred_y;
      logic [COUNT_BITS-1:0]  points_held;
   } box_result_type;

   typedef struct packed {
      logic                   new_track;
      logic [COORD_BITS-1:0]  box_left;
      logic [COORD_BITS-1:0]  box_top;
      logic [COORD_BITS:0]    box_width;
      logic [COORD_BITS:0]    box_height;
      logic                   typed;
      logic [CENTRE_BITS-1:0] center_x;
      logic [CENTRE_BITS-1:0] center_y;
      logic [PRED_BITS-1:0]   pred_x;
      logic [PRED_BITS-1:0]   pred_y;
      logic [COUNT_BITS-1:0]  points_held;
   } box_row_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_BITS-1:0] req_tdata  = '0;
   logic                req_tuser  = 1'b0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   int             sender_idle_pct    = 0;
   int             receiver_stall_pct = 0;
   int             fail_count         = 0;
   int             track_x [HIST_DEPTH];
   int             track_y [HIST_DEPTH];
   int             track_len          = 0;
   box_result_type pending_boxes [$];
   box_result_type want;
   box_result_type got;
   box_row_type    directed_rows [DIRECTED_ROWS];

   weighted_motion_predictor_unit #(.COORD_BITS(COORD_BITS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #10 clock = ~clock;

   initial begin
      #5_000_000;
      $display("weighted_motion_predictor_unit: mismatch");
      $finish;
   end

   function automatic int weighted_prediction(input int c0, input int c1, input int c2,
                                              input int c3, input int c4, input int n);
      int sum;
      int divisor;
      sum = 0;
      case (n)
         2:       divisor = DIV_PAIR;
         3:       divisor = DIV_THREE;
         4:       divisor = DIV_FOUR;
         default: divisor = DIV_FIVE;
      endcase
      if (n < 2) return c0;
      sum += (n - 1) * (c0 - c1);
      if (n > 2) sum += (n - 2) * (c1 - c2);
      if (n > 3) sum += (n - 3) * (c2 - c3);
      if (n > 4) sum += (n - 4) * (c3 - c4);
      if (sum >= 0) return c0 + (2*sum + divisor) / (2*divisor);
      return c0 - (-2*sum + divisor) / (2*divisor);
   endfunction

   task automatic track_box(input logic nt, input int l, input int t, input int w,
                            input int h, output box_result_type res);
      int cx;
      int cy;
      int px;
      int py;
      cx = ((2*l + w) >> 1) & ((1 << CENTRE_BITS) - 1);
      cy = ((2*t + h) >> 1) & ((1 << CENTRE_BITS) - 1);
      if (nt) begin
         for (int i = 0; i < HIST_DEPTH; i++) begin
            track_x[i] = 0;
            track_y[i] = 0;
         end
         track_len = 0;
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--) begin
         track_x[i] = track_x[i-1];
         track_y[i] = track_y[i-1];
      end
      track_x[0] = cx;
      track_y[0] = cy;
      if (track_len < HIST_DEPTH) track_len++;
      px = weighted_prediction(track_x[0], track_x[1], track_x[2], track_x[3], track_x[4],
                               track_len);
      py = weighted_prediction(track_y[0], track_y[1], track_y[2], track_y[3], track_y[4],
                               track_len);
      res.center_x    = cx[CENTRE_BITS-1:0];
      res.center_y    = cy[CENTRE_BITS-1:0];
      res.pred_x      = px[PRED_BITS-1:0];
      res.pred_y      = py[PRED_BITS-1:0];
      res.points_held = track_len[COUNT_BITS-1:0];
   endtask

   task automatic send_box(input box_row_type row);
      box_result_type res;
      while (int'($urandom_range(0, 99)) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.new_track;
      req_tdata  <= {row.box_height, row.box_width, row.box_top, row.box_left};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_box(row.new_track, row.box_left, row.box_top, row.box_width, row.box_height,
                res);
      if (row.typed) begin
         res = {row.center_x, row.center_y, row.pred_x, row.pred_y, row.points_held};
      end
      pending_boxes.insert(pending_boxes.size(), res);
   endtask

   function automatic int nudge(input int prev, input int lo, input int hi, input int span);
      int v;
      v = prev + int'($urandom_range(0, 2*span)) - span;
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[12:0], rsp_tdata[25:13], rsp_tdata[40:26], rsp_tdata[55:41],
                   rsp_tdata[58:56]};
            if (pending_boxes.size() == 0) begin
               $error("unexpected response with no request outstanding");
               fail_count++;
            end else begin
               want = pending_boxes.pop_front();
               if (got.center_x !== want.center_x) begin
                  $error("center_x: expected %0d, actual %0d", want.center_x, got.center_x);
                  fail_count++;
               end
               if (got.center_y !== want.center_y) begin
                  $error("center_y: expected %0d, actual %0d", want.center_y, got.center_y);
                  fail_count++;
               end
               if (got.pred_x !== want.pred_x) begin
                  $error("pred_x: expected %0d, actual %0d", $signed(want.pred_x),
                         $signed(got.pred_x));
                  fail_count++;
               end
               if (got.pred_y !== want.pred_y) begin
                  $error("pred_y: expected %0d, actual %0d", $signed(want.pred_y),
                         $signed(got.pred_y));
                  fail_count++;
               end
               if (got.points_held !== want.points_held) begin
                  $error("points_held: expected %0d, actual %0d", want.points_held,
                         got.points_held);
                  fail_count++;
               end
            end
         end
         rsp_tready <= (int'($urandom_range(0, 99)) >= receiver_stall_pct);
      end
   end

   initial begin
      box_row_type row;
      int          left;
      int          top;
      int          w;
      int          h;

      // The rows with a typed result are single points, whose prediction is the centre.
      directed_rows[0]  = '{1'b0, 12'd100, 12'd200, 13'd50, 13'd30,
                            1'b1, 13'd125, 13'd215, 15'd125, 15'd215, 3'd1};
      directed_rows[1]  = '{1'b0, 12'd110, 12'd205, 13'd50, 13'd30, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[2]  = '{1'b0, 12'd122, 12'd212, 13'd52, 13'd30, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[3]  = '{1'b0, 12'd130, 12'd214, 13'd50, 13'd32, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[4]  = '{1'b0, 12'd141, 12'd220, 13'd50, 13'd30, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[5]  = '{1'b0, 12'd150, 12'd224, 13'd50, 13'd30, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[6]  = '{1'b1, 12'd4095, 12'd4095, 13'd4096, 13'd4096,
                            1'b1, 13'd6143, 13'd6143, 15'd6143, 15'd6143, 3'd1};
      directed_rows[7]  = '{1'b0, 12'd0, 12'd0, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[8]  = '{1'b0, 12'd4095, 12'd4095, 13'd4096, 13'd4096,
                            1'b0, 0, 0, 0, 0, 0};
      directed_rows[9]  = '{1'b0, 12'd0, 12'd0, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[10] = '{1'b0, 12'd4095, 12'd0, 13'd4096, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[11] = '{1'b1, 12'd77, 12'd88, 13'd0, 13'd0,
                            1'b1, 13'd77, 13'd88, 15'd77, 15'd88, 3'd1};
      directed_rows[12] = '{1'b1, 12'd10, 12'd10, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[13] = '{1'b0, 12'd10, 12'd10, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[14] = '{1'b0, 12'd10, 12'd10, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[15] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[16] = '{1'b1, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[17] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[18] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[19] = '{1'b0, 12'd10, 12'd10, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[20] = '{1'b1, 12'd10, 12'd10, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[21] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[22] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[23] = '{1'b0, 12'd11, 12'd11, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};
      directed_rows[24] = '{1'b0, 12'd12, 12'd12, 13'd1, 13'd1, 1'b0, 0, 0, 0, 0, 0};

      for (int i = 0; i < HIST_DEPTH; i++) begin
         track_x[i] = 0;
         track_y[i] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIRECTED_ROWS; i++) send_box(directed_rows[i]);

      left = 2000;
      top  = 1500;
      w    = 64;
      h    = 48;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 80; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 80; end
            default: begin sender_idle_pct = 18; receiver_stall_pct = 18; end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 15) == 0) begin
               left = $urandom_range(0, MAX_COORD);
               top  = $urandom_range(0, MAX_COORD);
            end else begin
               left = nudge(left, 0, MAX_COORD, 48);
               top  = nudge(top, 0, MAX_COORD, 48);
            end
            if ($urandom_range(0, 7) == 0) begin
               w = $urandom_range(1, MAX_SIZE);
               h = $urandom_range(1, MAX_SIZE);
            end else begin
               w = nudge(w, 1, MAX_SIZE, 6);
               h = nudge(h, 1, MAX_SIZE, 6);
            end
            row = '0;
            row.new_track  = ($urandom_range(0, 11) == 0);
            row.box_left   = left[COORD_BITS-1:0];
            row.box_top    = top[COORD_BITS-1:0];
            row.box_width  = w[COORD_BITS:0];
            row.box_height = h[COORD_BITS:0];
            send_box(row);
         end
      end

      req_tvalid <= 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      while (pending_boxes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("weighted_motion_predictor_unit: match");
      end else begin
         $display("weighted_motion_predictor_unit: mismatch");
      end
      $finish;
   end

endmodule
